// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the interpolator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pli_pkg.sv =====
package pli_pkg;

   localparam int MaxPoints = 16;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = 5;
   localparam int DataW     = 32;
   localparam int CsrAddrW  = 1;

   localparam logic [0:0] OpLoad = 1'b0;
   localparam logic [0:0] OpEval = 1'b1;

   localparam logic [CsrAddrW-1:0] RegXCount = 1'b0;
   localparam logic [CsrAddrW-1:0] RegYCount = 1'b1;

   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StMismatch = 2'd1;
   localparam logic [1:0] StNoPoints = 2'd2;
   localparam logic [1:0] StZeroDx   = 2'd3;

   typedef struct packed {
      logic [0:0]             opcode;
      logic [3:0]             point_index;
      logic signed [DataW-1:0] point_x;
      logic signed [DataW-1:0] point_y;
      logic signed [DataW-1:0] x_value;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] y_value;
      logic [1:0]              status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;   // latch the request item
      logic            write_pt;  // write the captured point into the tables
      logic            rd_issue;  // marks a search read at rd_addr; unused by the datapath
      logic [IdxW-1:0] rd_addr;
      logic            cmp_step;  // marks the compare of read x against request x; unused by the datapath
      logic            load_lo;   // latch x0,y0 from read data
      logic            load_hi;   // latch x1,y1 from read data
      logic            diff;      // form dx, dy, ox
      logic            mul;       // form product
      logic            div_start; // initialise divider
      logic            div_step;  // one quotient bit
      logic            finish;    // form final sum
      logic            one_pt;    // result is y from read data
   } cmd_type;

   typedef struct packed {
      logic x_greater; // request x above read x
      logic dx_zero;
   } stat_type;

endpackage

// ===== hw/rtl/pli_if.sv =====
interface pli_req_if;
   import pli_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pli_rsp_if;
   import pli_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pli_ram.sv =====
module pli_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/pli_datapath.sv =====
module pli_datapath (
   input  logic              clock,
   input  pli_pkg::req_type  req_item,
   input  pli_pkg::cmd_type  cmd,
   output pli_pkg::stat_type stat,
   output logic signed [31:0] y_result
);
   import pli_pkg::*;

   req_type                 req_ff;
   logic [DataW-1:0]        rdx, rdy;
   logic signed [DataW-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [DataW-1:0]        mdx_ff, mdy_ff, mox_ff;
   logic                    neg_ff;
   logic [63:0]             prod_ff;
   logic [DataW-1:0]        rem_ff;
   logic [63:0]             quo_ff;
   logic signed [DataW-1:0] y_ff;
   logic signed [32:0]      dx, dy, ox;
   logic [32:0]             rem_sh;
   logic [34:0]             q_sat;
   logic signed [36:0]      sum;

   // Only the low index bits address the table; out-of-range slots are not
   // representable with a 4-bit index and MaxPoints of 16.
   pli_ram #(.Width(DataW), .Depth(MaxPoints)) u_xram (
      .clock, .wr_en(cmd.write_pt), .wr_addr(req_ff.point_index[IdxW-1:0]),
      .wr_data(req_ff.point_x), .rd_addr(cmd.rd_addr), .rd_data(rdx));
   pli_ram #(.Width(DataW), .Depth(MaxPoints)) u_yram (
      .clock, .wr_en(cmd.write_pt), .wr_addr(req_ff.point_index[IdxW-1:0]),
      .wr_data(req_ff.point_y), .rd_addr(cmd.rd_addr), .rd_data(rdy));

   assign dx = 33'(x1_ff) - 33'(x0_ff);
   assign dy = 33'(y1_ff) - 33'(y0_ff);
   assign ox = 33'(req_ff.x_value) - 33'(x0_ff);
   assign stat.x_greater = req_ff.x_value > $signed(rdx);
   assign stat.dx_zero   = (x1_ff == x0_ff);

   // Restoring division, one quotient bit per step, MSB of the product first.
   assign rem_sh = {rem_ff, prod_ff[63]};
   assign q_sat  = (quo_ff > 64'h4_0000_0000) ? 35'h4_0000_0000 : quo_ff[34:0];
   assign sum    = 37'(y0_ff) + (neg_ff ? -37'(q_sat) : 37'(q_sat));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.load_lo) begin
         x0_ff <= rdx;
         y0_ff <= rdy;
      end
      if (cmd.load_hi) begin
         x1_ff <= rdx;
         y1_ff <= rdy;
      end
      if (cmd.diff) begin
         mdx_ff <= dx[32] ? DataW'(-dx) : dx[31:0];
         mdy_ff <= dy[32] ? DataW'(-dy) : dy[31:0];
         mox_ff <= ox[32] ? DataW'(-ox) : ox[31:0];
         neg_ff <= (dy[32] != ox[32]) && (dy != 0) && (ox != 0);
      end
      if (cmd.mul) begin
         prod_ff <= 64'(mdy_ff) * 64'(mox_ff);
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= 33'(mdx_ff)) begin
            rem_ff <= DataW'(rem_sh - 33'(mdx_ff));
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         prod_ff <= {prod_ff[62:0], 1'b0};
      end
      // Each item starts from zero so loads and errors return zero.
      if (cmd.capture) begin
         y_ff <= '0;
      end else if (cmd.one_pt) begin
         y_ff <= rdy;
      end else if (cmd.finish) begin
         if (sum > 37'sh0_7FFF_FFFF) begin
            y_ff <= 32'sh7FFF_FFFF;
         end else if (sum < -37'sh0_8000_0000) begin
            y_ff <= 32'sh8000_0000;
         end else begin
            y_ff <= sum[31:0];
         end
      end
   end

   assign y_result = y_ff;
endmodule

// ===== hw/rtl/pli_control.sv =====
`include "assert_macros.svh"
module pli_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [0:0]               req_opcode,
   input  logic [pli_pkg::CntW-1:0] x_count,
   input  logic [pli_pkg::CntW-1:0] y_count,
   input  pli_pkg::stat_type        stat,
   output pli_pkg::cmd_type         cmd,
   output logic                     done,
   output logic [1:0]               status
);
   import pli_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CMP, S_LO_RD, S_LO_WAIT, S_HI_WAIT,
      S_CHECK, S_DIFF, S_MUL, S_DIV, S_FINISH, S_ONE_WAIT, S_DONE
   } state_type;

   state_type       state_ff;
   logic            op_ff;
   logic [IdxW-1:0] seg_ff;
   logic [6:0]      step_ff;
   logic [1:0]      status_ff;
   logic [CntW-1:0] n_eff;
   logic            last_seg;

   assign n_eff    = (x_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : x_count;
   assign last_seg = (CntW'(seg_ff) + CntW'(2)) >= n_eff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.capture = req_valid && req_ready;
      cmd.rd_addr = seg_ff + IdxW'(1);
      case (state_ff)
         S_DECODE:   cmd.write_pt = (op_ff == OpLoad);
         S_SRCH_RD:  cmd.rd_issue = 1'b1;
         S_SRCH_CMP: cmd.cmp_step = 1'b1;
         S_LO_RD: begin
            cmd.rd_addr = seg_ff;
         end
         S_LO_WAIT: begin
            cmd.load_lo = 1'b1;
         end
         S_HI_WAIT:  cmd.load_hi = 1'b1;
         S_DIFF:     cmd.diff = 1'b1;
         S_MUL: begin
            cmd.mul       = 1'b1;
            cmd.div_start = 1'b1;
         end
         S_DIV:      cmd.div_step = 1'b1;
         S_FINISH:   cmd.finish = 1'b1;
         S_ONE_WAIT: cmd.one_pt = 1'b1;
         default:    cmd.rd_addr = seg_ff + IdxW'(1);
      endcase
      if (state_ff == S_ONE_WAIT || state_ff == S_DECODE) begin
         cmd.rd_addr = '0;
      end
   end

   // S_LO_WAIT reads seg+1 while latching the low point.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_ff     <= OpLoad;
         seg_ff    <= '0;
         step_ff   <= '0;
         status_ff <= StOk;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_opcode;
                  seg_ff   <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               status_ff <= StOk;
               if (op_ff == OpLoad) begin
                  state_ff <= S_DONE;
               end else if (x_count != y_count) begin
                  status_ff <= StMismatch;
                  state_ff  <= S_DONE;
               end else if (n_eff == '0) begin
                  status_ff <= StNoPoints;
                  state_ff  <= S_DONE;
               end else if (n_eff == CntW'(1)) begin
                  state_ff <= S_ONE_WAIT;
               end else begin
                  state_ff <= S_SRCH_RD;
               end
            end
            S_SRCH_RD: begin
               state_ff <= last_seg ? S_LO_RD : S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
               if (stat.x_greater) begin
                  seg_ff   <= seg_ff + IdxW'(1);
                  state_ff <= S_SRCH_RD;
               end else begin
                  state_ff <= S_LO_RD;
               end
            end
            S_LO_RD:    state_ff <= S_LO_WAIT;
            S_LO_WAIT:  state_ff <= S_HI_WAIT;
            S_HI_WAIT:  state_ff <= S_CHECK;
            S_CHECK: begin
               if (stat.dx_zero) begin
                  status_ff <= StZeroDx;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF:     state_ff <= S_MUL;
            S_MUL: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'd63) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH:   state_ff <= S_DONE;
            S_ONE_WAIT: state_ff <= S_DONE;
            S_DONE:     state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   assign done   = (state_ff == S_DONE);
   assign status = status_ff;

   `ASSERT_IMPLY(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_ready,
      "ready while busy")
   `ASSERT_IMPLY(a_seg_range, clock, reset, state_ff == S_LO_RD,
      (CntW'(seg_ff) + CntW'(2)) <= n_eff, "segment beyond table")
   `ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready,
      state_ff == S_DECODE, "accepted item not decoded")
endmodule

// ===== hw/rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator over up to 16 signed 32-bit key points.
// req channel: opcode 0 loads point_x/point_y into slot point_index;
// opcode 1 evaluates at x_value. Every item yields exactly one rsp item
// with y_value and status (0 ok, 1 count mismatch, 2 no points,
// 3 zero-width segment); loads and errors return y_value 0.
// csr port: index 0 is the x point count, index 1 the y point count; write
// only while no item is in flight.
// A load or a count error goes from decode straight to the result; a single
// point reads slot 0 first. An evaluation walks the segments, comparing the
// request x against each upper x read from the table, then runs a 64-step
// restoring divider unless the segment has zero width.
// One item is in work at a time; the next can be taken in the cycle after the
// result moves to the output register.
// While a result waits there for a stalled receiver, no new item is taken.
// Reset (synchronous, active high) clears the counts and the controller;
// the point tables hold no reset and must be loaded before use.
module piecewise_linear_interpolator (
   input  logic                      clock,
   input  logic                      reset,
   pli_req_if.sink                   req,
   pli_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [pli_pkg::CsrAddrW-1:0] csr_index,
   input  logic [pli_pkg::CntW-1:0]  csr_write_data
);
   import pli_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic             done;
   logic [1:0]       status;
   logic signed [31:0] y_result;
   logic             core_ready;
   logic [CntW-1:0]  x_count_ff, y_count_ff;
   logic             out_valid_ff;
   rsp_type          out_ff;
   logic             hold;

   // The core stays idle while an earlier result still waits.
   assign hold      = out_valid_ff && !rsp.ready;
   assign req.ready = core_ready && !hold;

   pli_control u_control (
      .clock, .reset, .req_valid(req.valid && !hold), .req_ready(core_ready),
      .req_opcode(req.payload.opcode), .x_count(x_count_ff),
      .y_count(y_count_ff), .stat, .cmd, .done, .status);

   pli_datapath u_datapath (
      .clock, .req_item(req.payload), .cmd, .stat, .y_result);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff   <= '0;
         y_count_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == RegXCount) begin
            x_count_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == RegYCount) begin
            y_count_ff <= csr_write_data;
         end
         if (done) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         out_ff.status  <= status;
         out_ff.y_value <= (status == StOk) ? y_result : '0;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule

// ===== tb/sv/piecewise_linear_interpolator_tb.sv =====
module piecewise_linear_interpolator_tb;
   import pli_pkg::*;

   typedef enum logic [0:0] {RowItem, RowCsr} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      logic         typed;   // expectation typed in below rather than predicted
      rsp_type      want;
      logic [CsrAddrW-1:0] csr_idx;
      logic [CntW-1:0]     csr_val;
   } row_type;

   typedef struct {
      logic    typed;
      rsp_type want;
   } typed_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrAddrW-1:0] csr_index;
   logic [CntW-1:0]     csr_write_data;

   pli_req_if req_ch();
   pli_rsp_if rsp_ch();

   piecewise_linear_interpolator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the block: key point tables and both counts.
   logic signed [DataW-1:0] key_x [MaxPoints];
   logic signed [DataW-1:0] key_y [MaxPoints];
   logic [CntW-1:0] count_x;
   logic [CntW-1:0] count_y;

   rsp_type   pending_rsp_q[$];
   typed_type typed_q[$];
   row_type   rows[$];

   int errors;
   int rsp_count;
   int load_count;
   int status_count [4];
   bit calm;       // no idling on either side while set
   bit held_once;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d (result %0d)", what, got, want, rsp_count);
      errors++;
   endtask

   function automatic rsp_type predict_result(req_type r);
      rsp_type o;
      int n;
      int seg;
      longint x, x0, x1, y0, y1, dx, dy, ox, sq, sum;
      longint unsigned mdx, mdy, mox, q;
      bit neg;
      o.y_value = '0;
      o.status  = StOk;
      if (r.opcode == OpLoad) begin
         key_x[r.point_index] = r.point_x;
         key_y[r.point_index] = r.point_y;
      end else if (count_x != count_y) begin
         o.status = StMismatch;
      end else begin
         n = (count_x > MaxPoints) ? MaxPoints : int'(count_x);
         if (n == 0) begin
            o.status = StNoPoints;
         end else if (n == 1) begin
            o.y_value = key_y[0];
         end else begin
            x = longint'(r.x_value);
            seg = 0;
            while (seg + 2 < n && x > longint'(key_x[seg + 1])) seg++;
            x0 = longint'(key_x[seg]);
            x1 = longint'(key_x[seg + 1]);
            y0 = longint'(key_y[seg]);
            y1 = longint'(key_y[seg + 1]);
            dx = x1 - x0;
            dy = y1 - y0;
            ox = x - x0;
            if (dx == 0) begin
               o.status = StZeroDx;
            end else begin
               mdx = (dx < 0) ? -dx : dx;
               mdy = (dy < 0) ? -dy : dy;
               mox = (ox < 0) ? -ox : ox;
               neg = ((dy < 0) != (ox < 0)) && mdy != 0 && mox != 0;
               q = (mdy * mox) / mdx;
               if (q > 64'h4_0000_0000) q = 64'h4_0000_0000;
               sq = neg ? -longint'(q) : longint'(q);
               sum = y0 + sq;
               if (sum > 64'sd2147483647) sum = 64'sd2147483647;
               if (sum < -64'sd2147483648) sum = -64'sd2147483648;
               o.y_value = sum[DataW-1:0];
            end
         end
      end
      return o;
   endfunction

   // Prediction at acceptance, comparison at delivery.
   always @(posedge clock) begin
      typed_type t;
      rsp_type p;
      rsp_type w;
      if (!reset && req_ch.valid && req_ch.ready) begin
         p = predict_result(req_ch.payload);
         t = typed_q.pop_front();
         pending_rsp_q.push_back(t.typed ? t.want : p);
         if (req_ch.payload.opcode == OpLoad) load_count++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         status_count[rsp_ch.payload.status]++;
         if (pending_rsp_q.size() == 0) begin
            $display("result %0d arrived with nothing expected", rsp_count);
            errors++;
         end else begin
            w = pending_rsp_q.pop_front();
            if (rsp_ch.payload.y_value !== w.y_value)
               report("y_value", rsp_ch.payload.y_value, w.y_value);
            if (rsp_ch.payload.status !== w.status)
               report("status", rsp_ch.payload.status, w.status);
         end
      end
   end

   // Receiver: random hold-off per result, one long hold to back up the block.
   initial begin
      int d;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         d = calm ? 0 : $urandom_range(0, 17);
         if (!held_once && rsp_count >= 400) begin
            held_once = 1'b1;
            d = 600;
         end
         if (d > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (d) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_item(req_type r, logic typed, rsp_type want);
      typed_type t;
      int gap;
      t.typed = typed;
      t.want  = want;
      typed_q.push_back(t);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_count(logic [CsrAddrW-1:0] idx, logic [CntW-1:0] val);
      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == RegXCount) count_x = val;
      else count_y = val;
   endtask

   function automatic req_type make_item(logic [0:0] op, int idx, int px, int py, int xv);
      req_type r;
      r.opcode      = op;
      r.point_index = idx[3:0];
      r.point_x     = px;
      r.point_y     = py;
      r.x_value     = xv;
      return r;
   endfunction

   function automatic int rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 100) - 50;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return $urandom_range(0, 2000000) - 1000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(req_type r, logic typed, rsp_type want);
      row_type w;
      w.kind  = RowItem;
      w.item  = r;
      w.typed = typed;
      w.want  = want;
      rows.push_back(w);
   endtask

   task automatic add_csr(logic [CsrAddrW-1:0] idx, logic [CntW-1:0] val);
      row_type w;
      w.kind    = RowCsr;
      w.csr_idx = idx;
      w.csr_val = val;
      rows.push_back(w);
   endtask

   initial begin
      rsp_type ok0;
      rsp_type st;
      rsp_type none;
      int xs[$];
      int n;
      int k;
      int phase;
      int sent;
      int xv;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.payload   <= '0;
      count_x = '0;
      count_y = '0;
      calm = 1'b0;
      held_once = 1'b0;
      errors = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ok0  = '{y_value: '0, status: StOk};
      none = '0;
      st   = '{y_value: '0, status: StNoPoints};
      add_item(make_item(OpEval, 0, 0, 0, 0), 1'b1, st);
      add_csr(RegXCount, 5'd3);
      st.status = StMismatch;
      add_item(make_item(OpEval, 0, 0, 0, 7), 1'b1, st);
      add_item(make_item(OpLoad, 0, 32'sh80000000, 32'sh80000000, 0), 1'b1, ok0);
      add_item(make_item(OpLoad, 1, 0, 32'sh7fffffff, -1), 1'b1, ok0);
      add_item(make_item(OpLoad, 2, 32'sh7fffffff, 32'sh80000000, 0), 1'b1, ok0);
      add_item(make_item(OpLoad, 15, -5, 9, 0), 1'b1, ok0);
      add_csr(RegYCount, 5'd3);
      add_item(make_item(OpEval, 0, 0, 0, 32'sh80000000), 1'b0, none);
      add_item(make_item(OpEval, 15, -1, -1, 32'sh7fffffff), 1'b0, none);
      add_item(make_item(OpEval, 0, 0, 0, 0), 1'b0, none);
      add_item(make_item(OpEval, 0, 0, 0, -12345), 1'b0, none);
      add_csr(RegXCount, 5'd1);
      add_csr(RegYCount, 5'd1);
      st = '{y_value: 32'sh80000000, status: StOk};
      add_item(make_item(OpEval, 0, 0, 0, 99), 1'b1, st);
      add_csr(RegXCount, 5'd2);
      add_csr(RegYCount, 5'd2);
      add_item(make_item(OpEval, 0, 0, 0, 32'sh7fffffff), 1'b0, none);
      add_item(make_item(OpLoad, 1, 32'sh80000000, 5, 0), 1'b1, ok0);
      st = '{y_value: '0, status: StZeroDx};
      add_item(make_item(OpEval, 0, 0, 0, 3), 1'b1, st);
      add_csr(RegXCount, 5'd0);
      add_csr(RegYCount, 5'd0);
      st = '{y_value: '0, status: StNoPoints};
      add_item(make_item(OpEval, 0, 0, 0, 3), 1'b1, st);

      foreach (rows[i]) begin
         if (rows[i].kind == RowCsr) write_count(rows[i].csr_idx, rows[i].csr_val);
         else send_item(rows[i].item, rows[i].typed, rows[i].want);
      end

      // Fill every slot so that no evaluation can touch an unwritten entry.
      for (int s = 0; s < MaxPoints; s++)
         send_item(make_item(OpLoad, s, $urandom, $urandom, $urandom), 1'b0, none);

      sent = 0;
      phase = 0;
      while (sent < 1600) begin
         calm = (phase % 5 == 3);
         case (phase % 7)
            0: n = 16;
            1: n = 2;
            2: n = 31;   // saturates to the table size
            default: n = $urandom_range(0, 16);
         endcase
         write_count(RegXCount, n[CntW-1:0]);
         if ($urandom_range(0, 5) == 0)
            write_count(RegYCount, CntW'((n + $urandom_range(1, 30)) % 32));
         else
            write_count(RegYCount, n[CntW-1:0]);
         if (n > MaxPoints) n = MaxPoints;
         // Load a sorted table, now and then with a repeated x.
         xs.delete();
         for (int s = 0; s < n; s++) xs.push_back(rand_word());
         xs.sort();
         if (n >= 2 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, n - 2);
            xs[k + 1] = xs[k];
         end
         for (int s = 0; s < n; s++) begin
            send_item(make_item(OpLoad, s, xs[s], rand_word(), $urandom), 1'b0, none);
            sent++;
         end
         for (int j = 0; j < 70; j++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(make_item(OpLoad, $urandom_range(0, 15), rand_word(), rand_word(),
                                   $urandom), 1'b0, none);
            end else begin
               if (n > 0 && $urandom_range(0, 3) == 0) xv = key_x[$urandom_range(0, n - 1)];
               else xv = rand_word();
               send_item(make_item(OpEval, $urandom_range(0, 15), $urandom, $urandom, xv),
                         1'b0, none);
            end
            sent++;
         end
         phase++;
      end

      calm = 1'b0;
      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d results over %0d phases, %0d of them loads", rsp_count, phase,
               load_count);
      $display("status counts: ok %0d, mismatch %0d, no points %0d, zero width %0d",
               status_count[StOk], status_count[StMismatch], status_count[StNoPoints],
               status_count[StZeroDx]);
      if (errors == 0 && pending_rsp_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("timeout with %0d results outstanding", pending_rsp_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
